/* rtl/masked_word_pattern_search_macros.svh */
// Assertion macros shared by the masked word pattern search RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef MASKED_WORD_PATTERN_SEARCH_MACROS_SVH
`define MASKED_WORD_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MWPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MWPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mwps_pkg.sv */
// Package for the masked word pattern search: sizes, command type, helpers.
// No dependencies; used by every RTL module of the block.
package mwps_pkg;

  localparam int PATTERN_WORDS = 32;
  localparam int POSITION_BITS = 16;
  localparam int WORD_BITS     = 32;
  localparam int CFG_BITS      = 6;
  localparam int SLOT_BITS     = 5;
  localparam int OP_BITS       = 2;
  localparam int POS_OUT_BITS  = 16;

  localparam int LEN_BITS  = $clog2(PATTERN_WORDS + 1);
  localparam int IDX_BITS  = (PATTERN_WORDS > 1) ? $clog2(PATTERN_WORDS) : 1;
  localparam int WSH_BITS  = $clog2(WORD_BITS);
  localparam int SH_BITS   = LEN_BITS + WSH_BITS;
  localparam int WIN_BITS  = PATTERN_WORDS * WORD_BITS;

  localparam int IN_DATA_BITS  = ((SLOT_BITS + 3 * WORD_BITS) + 7) / 8 * 8;
  localparam int OUT_DATA_BITS = ((2 + POS_OUT_BITS) + 7) / 8 * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Classified command handed from the front end to the back end.
  // For loads val already holds pattern & mask.
  typedef struct packed {
    op_t                 op;
    logic [IDX_BITS-1:0] slot;
    word_t               val;
    word_t               mask;
    logic                last;
  } cmd_t;

  // Length in use: zero acts as one, anything above the table depth as the depth.
  function automatic logic [LEN_BITS-1:0] clamp_len(input logic [CFG_BITS-1:0] v);
    logic [LEN_BITS-1:0] r;
    if (v == '0) begin
      r = LEN_BITS'(1);
    end else if (int'(v) > PATTERN_WORDS) begin
      r = LEN_BITS'(PATTERN_WORDS);
    end else begin
      r = LEN_BITS'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/mwps_front.sv */
// Front end: takes input transfers, decodes the operation, registers a command.
// Depends on mwps_pkg.
module mwps_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mwps_pkg::IN_DATA_BITS-1:0] in_tdata,
  input  logic [mwps_pkg::OP_BITS-1:0]      in_tuser,
  input  logic                              in_tlast,
  input  logic                              q_ready,
  output logic                              q_push,
  output mwps_pkg::cmd_t                    q_cmd
);
  import mwps_pkg::*;

  logic                 dec_v_r, dec_v_nxt;
  cmd_t                 dec_r, dec_nxt;
  logic [SLOT_BITS-1:0] slot_f;
  word_t                pword_f, mword_f, dword_f;

  assign slot_f  = in_tdata[SLOT_BITS-1:0];
  assign pword_f = in_tdata[SLOT_BITS +: WORD_BITS];
  assign mword_f = in_tdata[SLOT_BITS + WORD_BITS +: WORD_BITS];
  assign dword_f = in_tdata[SLOT_BITS + 2 * WORD_BITS +: WORD_BITS];

  assign in_tready = !dec_v_r || q_ready;
  assign q_push    = dec_v_r && q_ready;
  assign q_cmd     = dec_r;

  always_comb begin
    dec_nxt.op   = OP_NOP;
    dec_nxt.slot = IDX_BITS'(slot_f);
    dec_nxt.val  = '0;
    dec_nxt.mask = '0;
    dec_nxt.last = 1'b0;
    unique case (op_t'(in_tuser))
      OP_LOAD: begin
        // slots beyond the table are dropped here
        if (int'(slot_f) < PATTERN_WORDS) begin
          dec_nxt.op   = OP_LOAD;
          dec_nxt.val  = pword_f & mword_f;
          dec_nxt.mask = mword_f;
        end
      end
      OP_SCAN: begin
        dec_nxt.op   = OP_SCAN;
        dec_nxt.val  = dword_f;
        dec_nxt.last = in_tlast;
      end
      OP_CLEAR: begin
        dec_nxt.op = OP_CLEAR;
      end
      default: begin
        dec_nxt.op = OP_NOP;
      end
    endcase
  end

  assign dec_v_nxt = in_tready ? in_tvalid : dec_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else begin
      dec_v_r <= dec_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

/* rtl/mwps_queue.sv */
// Short command queue between front and back ends.
// Depends on mwps_pkg.
module mwps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mwps_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output mwps_pkg::cmd_t pop_cmd
);
  import mwps_pkg::*;

  cmd_t                  mem_r [QUEUE_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r, count_nxt;

  assign push_ready = (count_r != Q_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/mwps_back.sv */
// Back end: pattern tables, sliding window compare, first-match tracking,
// length register and the output register. Depends on mwps_pkg and the macros.
`include "masked_word_pattern_search_macros.svh"

module mwps_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mwps_pkg::CFG_BITS-1:0]      cfg_wr_data,
  input  logic                               q_valid,
  input  mwps_pkg::cmd_t                     q_cmd,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mwps_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                               out_tlast
);
  import mwps_pkg::*;

  word_t pat_r [PATTERN_WORDS];
  word_t msk_r [PATTERN_WORDS];
  word_t win_r [PATTERN_WORDS];
  word_t win_nxt [PATTERN_WORDS];
  word_t win_shift [PATTERN_WORDS];

  logic [LEN_BITS-1:0]      len_r;
  logic [LEN_BITS-1:0]      len_m1;
  logic [LEN_BITS-1:0]      sh_words;
  logic [SH_BITS-1:0]       sh_amt;
  logic [WIN_BITS-1:0]      rev_flat;
  logic [WIN_BITS-1:0]      aligned;
  logic [PATTERN_WORDS-1:0] slot_ok;
  logic                     win_hit, enough, hit;

  logic [POSITION_BITS-1:0] seen_r, seen_nxt;
  logic [POSITION_BITS-1:0] first_pos_r, first_pos_nxt;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     found_r, found_nxt;

  logic                     out_v_r, out_v_nxt;
  logic                     out_match_r, out_match_nxt;
  logic                     out_found_r;
  logic [POS_OUT_BITS-1:0]  out_pos_r;
  logic                     out_done_r, out_done_nxt;

  assign q_pop = q_valid && (!out_v_r || out_tready);

  // Window after this word goes in; entry 0 is the newest.
  always_comb begin
    win_shift[0] = q_cmd.val;
    for (int k = 1; k < PATTERN_WORDS; k++) begin
      win_shift[k] = win_r[k-1];
    end
  end

  // Slot i meets the word len-1-i back: reverse the window and drop the
  // PATTERN_WORDS-len oldest words so slot i lines up with word i.
  always_comb begin
    for (int j = 0; j < PATTERN_WORDS; j++) begin
      rev_flat[j*WORD_BITS +: WORD_BITS] = win_shift[PATTERN_WORDS-1-j];
    end
  end

  assign len_m1   = len_r - 1'b1;
  assign sh_words = LEN_BITS'(PATTERN_WORDS) - len_r;
  assign sh_amt   = SH_BITS'(sh_words) << WSH_BITS;
  assign aligned  = rev_flat >> sh_amt;

  always_comb begin
    for (int i = 0; i < PATTERN_WORDS; i++) begin
      slot_ok[i] = (LEN_BITS'(i) >= len_r) ||
                   ((aligned[i*WORD_BITS +: WORD_BITS] & msk_r[i]) == pat_r[i]);
    end
  end

  assign win_hit   = &slot_ok;
  assign enough    = (seen_r >= POSITION_BITS'(len_m1));
  assign hit       = win_hit && enough;
  assign start_pos = seen_r - POSITION_BITS'(len_m1);

  always_comb begin
    win_nxt       = win_r;
    seen_nxt      = seen_r;
    found_nxt     = found_r;
    first_pos_nxt = first_pos_r;
    out_match_nxt = 1'b0;
    out_done_nxt  = 1'b0;
    unique case (q_cmd.op)
      OP_SCAN: begin
        win_nxt = win_shift;
        if (seen_r != '1) begin
          seen_nxt = seen_r + 1'b1;
        end
        if (hit && !found_r) begin
          found_nxt     = 1'b1;
          first_pos_nxt = start_pos;
        end
        out_match_nxt = hit;
        out_done_nxt  = q_cmd.last;
      end
      OP_CLEAR: begin
        for (int k = 0; k < PATTERN_WORDS; k++) begin
          win_nxt[k] = '0;
        end
        seen_nxt      = '0;
        found_nxt     = 1'b0;
        first_pos_nxt = '0;
      end
      OP_LOAD, OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (q_pop) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_BITS'(1);
      seen_r      <= '0;
      found_r     <= 1'b0;
      first_pos_r <= '0;
      out_v_r     <= 1'b0;
      for (int k = 0; k < PATTERN_WORDS; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        len_r <= clamp_len(cfg_wr_data);
      end
      out_v_r <= out_v_nxt;
      if (q_pop) begin
        win_r       <= win_nxt;
        seen_r      <= seen_nxt;
        found_r     <= found_nxt;
        first_pos_r <= first_pos_nxt;
      end
    end
  end

  // Tables: no reset, contents undefined until loaded.
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_LOAD) begin
      pat_r[q_cmd.slot] <= q_cmd.val;
      msk_r[q_cmd.slot] <= q_cmd.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_match_r <= out_match_nxt;
      out_found_r <= found_nxt;
      out_pos_r   <= POS_OUT_BITS'(first_pos_nxt);
      out_done_r  <= out_done_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_done_r;

  always_comb begin
    out_tdata                  = '0;
    out_tdata[0]               = out_match_r;
    out_tdata[1]               = out_found_r;
    out_tdata[2 +: POS_OUT_BITS] = out_pos_r;
  end

  `MWPS_ASSERT_SAME(a_hit_implies_found, out_v_r && out_match_r, out_found_r, "match without found")
  `MWPS_ASSERT_NEXT(a_found_sticky, found_r && !(q_pop && q_cmd.op == OP_CLEAR), found_r, "found dropped without clear")
  `MWPS_ASSERT_NEXT(a_pos_held, found_r && !(q_pop && q_cmd.op == OP_CLEAR), first_pos_r == $past(first_pos_r), "first position moved")
  `MWPS_ASSERT_NEXT(a_match_scan_only, q_pop && q_cmd.op != OP_SCAN, !out_match_r, "match flagged on a non-scan item")

endmodule

/* rtl/masked_word_pattern_search.sv */
// Masked word pattern search: top level joining front end, queue and back end.
// Depends on mwps_pkg, mwps_front, mwps_queue and mwps_back.
//
// Use: each input transfer carries one item. in_tuser selects the operation
// (load a pattern slot with its mask, scan a data word, clear the search, or
// a no-op). A scan shifts data_word into the window and reports whether the
// last pattern_length words match the masked pattern; the start index of the
// first match since clear is latched and reported on every result.
// Every input transfer yields exactly one output transfer, in order.
// The user must write pattern_length on cfg_wr_en only while the block is idle; the block does not enforce it.
// Path from input transfer to out_tvalid: decode register, queue, output
// register. Throughput: one item per cycle while out_tready stays high; the
// window compare in the back end is combinational.
// Stalls: when out_tready is low the result holds; the queue and decode
// register absorb up to three more items before in_tready drops.
// Reset (rst_n low, synchronous): window and counters cleared, length 1,
// no results pending. Pattern and mask slots are not cleared and must be
// loaded before a scan compares against them.
module masked_word_pattern_search (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: pattern_length
  input  logic                               cfg_wr_en,
  input  logic [mwps_pkg::CFG_BITS-1:0]      cfg_wr_data,
  // Input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [4:0] entry_index, [36:5] pattern_word, [68:37] mask_word,
  // [100:69] data_word, [103:101] zero
  input  logic [mwps_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [1:0] operation
  input  logic [mwps_pkg::OP_BITS-1:0]       in_tuser,
  input  logic                               in_tlast,   // last_word
  // Results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] window_match, [1] found, [17:2] match_position, [23:18] zero
  output logic [mwps_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                               out_tlast   // search_done
);
  import mwps_pkg::*;

  logic q_push, q_ready, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;

  mwps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mwps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  mwps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (pop_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

/* dv/tb_masked_word_pattern_search.sv */
// Self-checking testbench for masked_word_pattern_search: a queue-fed driver, a result
// monitor and an item-level predictor of the masked sliding-window search.
// Depends on mwps_pkg and the masked_word_pattern_search RTL.
module tb_masked_word_pattern_search;
  import mwps_pkg::*;

  // Slowest legal run is roughly 70k items; the limit allows several times that.
  localparam int          LIMIT_CYCLES = 600_000;
  localparam int          SEEN_MAX     = (1 << POSITION_BITS) - 1;
  localparam int          RANDOM_ITEMS = 2000;
  // Length settings swept first: zero, all ones, the table depth, just above and below it, small values.
  localparam logic [CFG_BITS-1:0] LEN_SWEEP [7] = '{6'd0, 6'd63, 6'd32, 6'd33, 6'd1, 6'd2,
                                                    6'd31};

  typedef struct {
    op_t                  op;
    logic [SLOT_BITS-1:0] slot;
    word_t                pat;
    word_t                msk;
    word_t                dat;
    logic                 last;
  } search_item_t;

  typedef struct {
    logic                    hit;
    logic                    found;
    logic [POS_OUT_BITS-1:0] pos;
    logic                    done;
  } search_result_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_wr_en   = 1'b0;
  logic [CFG_BITS-1:0]      cfg_wr_data = '0;
  logic                     in_tvalid   = 1'b0;
  logic [IN_DATA_BITS-1:0]  in_tdata    = '0;
  logic [OP_BITS-1:0]       in_tuser    = '0;
  logic                     in_tlast    = 1'b0;
  logic                     out_tready  = 1'b0;
  logic                     in_tready;
  logic                     out_tvalid;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  masked_word_pattern_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    // [4:0] entry_index, [36:5] pattern_word, [68:37] mask_word, [100:69] data_word
    .in_tdata    (in_tdata),
    // [1:0] operation
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // [0] window_match, [1] found, [17:2] match_position
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Predictor state: its own copy of the tables, the window and the search counters.
  // ---------------------------------------------------------------------------------------------
  word_t                    pat_tab   [PATTERN_WORDS];
  word_t                    msk_tab   [PATTERN_WORDS];
  word_t                    win_words [PATTERN_WORDS];   // entry 0 is the newest word
  logic [POSITION_BITS-1:0] seen_cnt   = '0;
  logic                     found_flag = 1'b0;
  logic [POSITION_BITS-1:0] first_pos  = '0;
  logic [CFG_BITS-1:0]      len_reg    = CFG_BITS'(1);

  search_item_t   item_backlog [$];      // items waiting for the driver
  search_result_t expected_results [$];  // predicted results not yet seen on the output
  search_item_t   item_on_bus;
  int unsigned    cyc          = 0;
  int             mismatches   = 0;
  int             random_items = 0;

  // Stimulus-side copy of the pattern loaded for the current phase.
  word_t          stim_pat [PATTERN_WORDS];
  word_t          stim_msk [PATTERN_WORDS];
  bit             stim_periodic;

  // Applies one item to the predicted state and returns the result it should produce.
  function automatic search_result_t predict_search(search_item_t it);
    search_result_t r;
    int             len;
    int             back;
    bit             hit;
    r   = '{1'b0, 1'b0, '0, 1'b0};
    hit = 1'b0;
    case (it.op)
      OP_LOAD: begin
        pat_tab[it.slot] = it.pat;
        msk_tab[it.slot] = it.msk;
      end
      OP_SCAN: begin
        // Length zero acts as one; anything beyond the table depth acts as the depth.
        len = int'(len_reg);
        if (len == 0) len = 1;
        if (len > PATTERN_WORDS) len = PATTERN_WORDS;
        for (int k = PATTERN_WORDS - 1; k > 0; k--) win_words[k] = win_words[k-1];
        win_words[0] = it.dat;
        // Need a full window since clear; slot i meets the word len-1-i scans back.
        if (int'(seen_cnt) >= len - 1) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++) begin
            back = len - 1 - i;
            if ((win_words[back] & msk_tab[i]) != (pat_tab[i] & msk_tab[i])) hit = 1'b0;
          end
        end
        if (hit) begin
          r.hit = 1'b1;
          if (!found_flag) begin
            found_flag = 1'b1;
            first_pos  = seen_cnt - POSITION_BITS'(len - 1);
          end
        end
        // Position counter saturates, so later positions stay pinned at the top.
        if (int'(seen_cnt) != SEEN_MAX) seen_cnt = seen_cnt + 1'b1;
        r.done = it.last;
      end
      OP_CLEAR: begin
        foreach (win_words[k]) win_words[k] = '0;
        seen_cnt   = '0;
        found_flag = 1'b0;
        first_pos  = '0;
      end
      default: ;  // no-op leaves everything alone
    endcase
    r.found = found_flag;
    r.pos   = first_pos[POS_OUT_BITS-1:0];
    return r;
  endfunction

  // Random back-pressure and gaps, switched off in recurring calm stretches.
  function automatic bit gap_now();
    return (((cyc / 3000) % 5) != 2) && ($urandom_range(99) < 14);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Driver: one transfer per handshake; prediction happens at the accepting edge.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_search(item_on_bus));
      // Only move on once the current item has gone (or nothing is on the bus).
      if (!in_tvalid || in_tready) begin
        if (item_backlog.size() != 0 && !gap_now()) begin
          item_on_bus = item_backlog.pop_front();
          in_tvalid  <= 1'b1;
          in_tdata   <= {3'b000, item_on_bus.dat, item_on_bus.msk, item_on_bus.pat,
                         item_on_bus.slot};
          in_tuser   <= item_on_bus.op;
          in_tlast   <= item_on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Monitor: every result transfer is checked field by field against the oldest prediction.
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    search_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with nothing expected", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[0] !== want.hit)
            report_mismatch($sformatf("window_match %b, want %b", out_tdata[0], want.hit));
          if (out_tdata[1] !== want.found)
            report_mismatch($sformatf("found %b, want %b", out_tdata[1], want.found));
          if (out_tdata[17:2] !== want.pos)
            report_mismatch($sformatf("match_position %0d, want %0d", out_tdata[17:2],
                                      want.pos));
          if (out_tlast !== want.done)
            report_mismatch($sformatf("search_done %b, want %b", out_tlast, want.done));
        end
      end
      out_tready <= !gap_now();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("tb_masked_word_pattern_search: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers. Fields an operation ignores are filled with random bits.
  // ---------------------------------------------------------------------------------------------
  task automatic push_item(op_t op, logic [SLOT_BITS-1:0] slot, word_t p, word_t m, word_t d,
                           logic last);
    search_item_t it;
    it = '{op, slot, p, m, d, last};
    item_backlog.push_back(it);
    if (op != OP_NOP) random_items++;
  endtask

  task automatic send_load(int s, word_t p, word_t m);
    push_item(OP_LOAD, SLOT_BITS'(s), p, m, $urandom, 1'($urandom));
  endtask

  task automatic send_scan(word_t d, logic last);
    push_item(OP_SCAN, SLOT_BITS'($urandom), $urandom, $urandom, d, last);
  endtask

  task automatic send_clear();
    push_item(OP_CLEAR, SLOT_BITS'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  task automatic send_nop();
    push_item(OP_NOP, SLOT_BITS'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  // Block is idle once nothing is queued, on the bus or owed; sampled on the falling edge so
  // the driver's updates at the rising edge have settled. Then allow the pipeline latency.
  task automatic drain();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(logic [CFG_BITS-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    len_reg      = v;
    cfg_wr_en   <= 1'b0;
  endtask

  // Word that satisfies slot k: masked bits from the pattern, the rest random (the pattern word itself when periodic).
  function automatic word_t planted(int k);
    if (stim_periodic) return stim_pat[k];
    return (stim_pat[k] & stim_msk[k]) | ($urandom & ~stim_msk[k]);
  endfunction

  // One phase: set the length, load every slot in use, clear, then scan several regions
  // made mostly of planted occurrences, broken occurrences and noise.
  task automatic run_phase(logic [CFG_BITS-1:0] setting);
    int    eff;
    int    off;
    int    per;
    int    rlen;
    int    w;
    int    pick;
    int    part;
    int    s;
    word_t base [3];
    word_t flip;
    set_length(setting);
    eff = (setting == 0) ? 1 : (int'(setting) > PATTERN_WORDS) ? PATTERN_WORDS : int'(setting);
    stim_periodic = ($urandom_range(9) < 3);
    per = $urandom_range(1, 3);
    foreach (base[i]) base[i] = $urandom;
    for (int i = 0; i < eff; i++) begin
      if (stim_periodic) begin
        // Repeating pattern: a longer run of the same period matches at overlapping starts.
        stim_pat[i] = base[i % per];
        stim_msk[i] = ($urandom_range(3) == 0) ? word_t'($urandom) : '1;
      end else begin
        stim_pat[i] = $urandom;
        case ($urandom_range(7))
          0, 1:    stim_msk[i] = '1;
          2, 3:    stim_msk[i] = $urandom;
          4, 5:    stim_msk[i] = $urandom & $urandom & $urandom;
          6:       stim_msk[i] = '0;
          default: stim_msk[i] = ~(word_t'(1) << $urandom_range(31));
        endcase
      end
    end
    off = $urandom_range(eff - 1);
    for (int k = 0; k < eff; k++) begin
      s = (k + off) % eff;
      send_load(s, stim_pat[s], stim_msk[s]);
    end
    send_clear();
    repeat ($urandom_range(1, 4)) begin
      rlen = $urandom_range(eff, 4 * eff + 8);
      w    = 0;
      while (w < rlen) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          for (int k = 0; k < eff; k++) send_scan(planted(k), 1'b0);
          w += eff;
          if (stim_periodic) begin
            part = $urandom_range(2 * per);
            for (int j = 0; j < part; j++) send_scan(base[(eff + j) % per], 1'b0);
            w += part;
          end
        end else if (pick < 50) begin
          // Broken occurrence: a prefix, then a word wrong in one compared bit, if the slot compares any.
          part = $urandom_range(eff - 1);
          for (int k = 0; k < part; k++) send_scan(planted(k), 1'b0);
          flip = '0;
          if (stim_msk[part] != '0) begin
            while ((flip & stim_msk[part]) == '0) flip = word_t'(1) << $urandom_range(31);
          end
          send_scan(planted(part) ^ flip, 1'b0);
          w += part + 1;
        end else if (pick < 90) begin
          send_scan(($urandom_range(1) == 0) ? word_t'($urandom) : planted($urandom_range(eff-1)),
                    ($urandom_range(19) == 0));
          w++;
        end else if (pick < 94) begin
          send_nop();
        end else if (pick < 97) begin
          // Reload a slot in use: unmasked bits change, behaviour must not.
          s = $urandom_range(eff - 1);
          send_load(s, stim_pat[s] ^ ($urandom & ~stim_msk[s]), stim_msk[s]);
        end else begin
          send_clear();
          w++;
        end
      end
      send_scan($urandom, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------------
  initial begin : stimulus
    word_t d;
    int    phase;
    foreach (win_words[k]) begin
      win_words[k] = '0;
      pat_tab[k]   = '0;
      msk_tab[k]   = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at the reset length of one.
    send_load(0, '1, '1);
    send_scan('0, 1'b0);                     // no match
    send_scan('1, 1'b0);                     // first match, at index one
    send_scan('1, 1'b1);                     // second match keeps the first position
    send_nop();
    send_clear();
    send_scan('1, 1'b0);                     // match at index zero after clear
    send_load(0, '0, '0);                    // empty mask matches anything
    send_scan(32'h1234_5678, 1'b1);
    send_load(PATTERN_WORDS - 1, '1, '0);    // top slot
    send_load(0, 32'h0000_0001, 32'h8000_0001);
    send_scan(32'h0000_0001, 1'b0);          // match on the two compared bits
    send_scan(32'h8000_0001, 1'b0);          // top compared bit differs
    send_scan(32'h7FFF_FFFF, 1'b0);          // unmasked bits all differ, still a match
    send_clear();
    send_nop();
    send_scan('0, 1'b1);
    drain();

    // Length sweep with the extremes first, then random settings, mostly short.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase < 7) run_phase(LEN_SWEEP[phase]);
      else if ($urandom_range(9) < 7) run_phase(CFG_BITS'($urandom_range(1, 6)));
      else run_phase(CFG_BITS'($urandom_range(0, 63)));
      phase++;
    end

    // Counter saturation: a full-mask pattern of three words that no noise word can end,
    // then the pattern itself once the index has stuck at its maximum.
    set_length(CFG_BITS'(3));
    stim_periodic = 1'b0;
    for (int k = 0; k < 3; k++) begin
      stim_pat[k] = $urandom;
      stim_msk[k] = '1;
      send_load(k, stim_pat[k], stim_msk[k]);
    end
    send_clear();
    for (int n = 0; n < SEEN_MAX + 4; n++) begin
      d = $urandom;
      while (d == stim_pat[2]) d = $urandom;
      send_scan(d, (n == 1000));
    end
    for (int k = 0; k < 3; k++) send_scan(stim_pat[k], 1'b0);
    for (int k = 0; k < 3; k++) send_scan(planted(k), (k == 2));
    send_clear();
    for (int k = 0; k < 3; k++) send_scan(planted(k), (k == 2));

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_masked_word_pattern_search: PASS");
    end else begin
      $display("tb_masked_word_pattern_search: FAIL");
    end
    $finish;
  end

endmodule
